// ===== rtl/scfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the sync/checksum frame parser.
// Holds the window geometry, the sync byte reset value and the frame record
// that passes from the window logic to the result register.
// ----------------------------------------------------------------------------
package scfp_pkg;

  // A frame is eleven bytes. The checksum covers the first ten.
  localparam int unsigned FrameLen = 11;
  localparam int unsigned SumLen   = 10;

  // Only ten bytes are ever held. The eleventh is the incoming byte itself.
  localparam int unsigned WinDepth = FrameLen - 1;
  localparam int unsigned CntW     = $clog2(WinDepth + 1);

  localparam logic [7:0] SyncReset = 8'h55;

  typedef logic [7:0]      byte_t;
  typedef logic [15:0]     word_t;
  typedef logic [CntW-1:0] count_t;

  // Decoded frame, together with the flag that says it passed both checks.
  typedef struct packed {
    logic  hit;
    byte_t frame_type;
    word_t word_zero;
    word_t word_one;
    word_t word_two;
    word_t word_three;
  } frame_t;

endpackage

// ===== rtl/scfp_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_window: byte window, sync test and checksum test.
// Keeps up to ten received bytes. When ten are held, the incoming byte is
// the checksum of a candidate frame; the frame is reported combinationally
// and the window either empties (hit) or slides by one (miss).
// ----------------------------------------------------------------------------
module scfp_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  scfp_pkg::byte_t     byte_i,
  input  scfp_pkg::byte_t     sync_i,
  output scfp_pkg::frame_t    frame_o
);

  scfp_pkg::byte_t  win_q [scfp_pkg::WinDepth];
  scfp_pkg::count_t count_q;
  scfp_pkg::count_t count_d;
  logic             full;
  scfp_pkg::byte_t  sum;

  assign full = (count_q == scfp_pkg::count_t'(scfp_pkg::WinDepth));

  // Modulo-256 sum of the ten held bytes as a balanced adder tree.
  always_comb begin
    sum = ((win_q[0] + win_q[1]) + (win_q[2] + win_q[3]))
        + ((win_q[4] + win_q[5]) + (win_q[6] + win_q[7]))
        + (win_q[8] + win_q[9]);
  end

  // Frame fields come straight from the held bytes, words little-endian.
  always_comb begin
    frame_o.hit        = full && (win_q[0] == sync_i) && (sum == byte_i);
    frame_o.frame_type = win_q[1];
    frame_o.word_zero  = {win_q[3], win_q[2]};
    frame_o.word_one   = {win_q[5], win_q[4]};
    frame_o.word_two   = {win_q[7], win_q[6]};
    frame_o.word_three = {win_q[9], win_q[8]};
  end

  // Fill count: grows until full, clears on a frame, holds on a slide.
  always_comb begin
    count_d = count_q;
    if (step_i) begin
      if (!full) begin
        count_d = count_q + scfp_pkg::count_t'(1);
      end else if (frame_o.hit) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Window bytes: append at the fill point, or shift down on a miss.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      if (!full) begin
        win_q[count_q] <= byte_i;
      end else if (!frame_o.hit) begin
        for (int i = 0; i < scfp_pkg::WinDepth - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[scfp_pkg::WinDepth-1] <= byte_i;
      end
    end
  end

  // The count never passes the window depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= scfp_pkg::count_t'(scfp_pkg::WinDepth))
    else $error("fill count beyond window depth");

  // An accepted frame leaves an empty window.
  a_hit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && frame_o.hit |=> count_q == '0)
    else $error("window not emptied after frame");

  // A byte taken while not full raises the count by one.
  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !full |=> count_q == $past(count_q) + scfp_pkg::count_t'(1))
    else $error("fill count did not advance");

  // A miss on a full window keeps it full.
  a_slide_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && full && !frame_o.hit |=> full)
    else $error("window not full after slide");

endmodule

// ===== rtl/sync_checksum_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_checksum_frame_parser_core: sync/checksum frame parser, top level.
// Takes one link byte per request and returns a decoded frame whenever an
// eleven-byte window opens with the sync byte and carries a valid checksum.
//
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_valid_i/cfg_ready_o  cfg_data_i (sync byte)
//   in       in         in_valid_i/in_stall_o    rx_byte_i
//   out      out        out_valid_o/out_stall_i  frame_type_o, word_*_o
//
// One byte is accepted per cycle while no frame is held stalled in the
// result register. A byte lands in the input register, then the window and
// checksum logic reports any frame into the result register. The input
// register stalls only while a frame sits stalled in the result register.
// Reset empties the window and sets the sync byte to 0x55.
// ----------------------------------------------------------------------------
module sync_checksum_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_type_o,
  output logic [15:0] word_zero_o,
  output logic [15:0] word_one_o,
  output logic [15:0] word_two_o,
  output logic [15:0] word_three_o
);

  scfp_pkg::byte_t  sync_q;
  logic             in_vld_q;
  scfp_pkg::byte_t  in_byte_q;
  logic             out_vld_q;
  scfp_pkg::frame_t out_q;
  scfp_pkg::frame_t frame;
  logic             adv;
  logic             step;
  logic             in_take;

  // Sync byte register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= scfp_pkg::SyncReset;
    end else if (cfg_valid_i) begin
      sync_q <= cfg_data_i;
    end
  end

  // The pipeline moves when the result register is free or being drained.
  assign adv        = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv || !in_vld_q) begin
      in_vld_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  scfp_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .sync_i  (sync_q),
    .frame_o (frame)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= step && frame.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && frame.hit) begin
      out_q <= frame;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign frame_type_o = out_q.frame_type;
  assign word_zero_o  = out_q.word_zero;
  assign word_one_o   = out_q.word_one;
  assign word_two_o   = out_q.word_two;
  assign word_three_o = out_q.word_three;

  // A new frame appears only from a hit on a processed byte.
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(step && frame.hit))
    else $error("frame without a checked window");

  // A stalled frame stays put and blocks the window.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |-> !step)
    else $error("window advanced over a stalled frame");

  // A held input byte is never dropped while stalled.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q))
    else $error("input register lost a stalled byte");

endmodule

// ===== test/sync_checksum_frame_parser_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_checksum_frame_parser_core_test: self-checking bench for the parser.
// Streams link bytes into the parser: good frames with random content, frames
// with a bad checksum, a wrong header or a missing byte, and loose noise
// bytes. A model of the eleven-byte sliding window predicts every decoded
// frame. Each frame that leaves the parser is checked field by field. The
// sync byte is changed between phases, and the sender and receiver idle at
// random, at rates set per phase.
// ----------------------------------------------------------------------------
module sync_checksum_frame_parser_core_test;

  localparam int CycleLimit   = 200000;
  localparam int DrainLimit   = 2000;
  localparam int SettleCycles = 4;

  // Ways in which a generated frame is damaged.
  typedef enum int {FlawNone, FlawChecksum, FlawHeader, FlawShort} flaw_e;
  // Content of the bytes between the header and the checksum.
  typedef enum int {BodyRandom, BodyOnes, BodyZeros} body_e;

  typedef struct packed {
    scfp_pkg::byte_t frame_type;
    scfp_pkg::word_t word_zero;
    scfp_pkg::word_t word_one;
    scfp_pkg::word_t word_two;
    scfp_pkg::word_t word_three;
  } frame_rec_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            cfg_valid_i  = 1'b0;
  logic            cfg_ready_o;
  scfp_pkg::byte_t cfg_data_i   = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  scfp_pkg::byte_t rx_byte_i    = '0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  scfp_pkg::byte_t frame_type_o;
  scfp_pkg::word_t word_zero_o;
  scfp_pkg::word_t word_one_o;
  scfp_pkg::word_t word_two_o;
  scfp_pkg::word_t word_three_o;

  // Stimulus and prediction state.
  scfp_pkg::byte_t link_bytes[$];
  frame_rec_t      frames_due[$];
  scfp_pkg::byte_t held_bytes[scfp_pkg::FrameLen];
  int              held_count     = 0;
  scfp_pkg::byte_t sync_setting   = scfp_pkg::SyncReset;
  int              bytes_queued   = 0;
  int              bytes_accepted = 0;
  int              frames_checked = 0;
  int              error_count    = 0;
  int              cycle_count    = 0;
  int              send_idle_pct  = 0;
  int              recv_idle_pct  = 0;

  sync_checksum_frame_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_type_o (frame_type_o),
    .word_zero_o  (word_zero_o),
    .word_one_o   (word_one_o),
    .word_two_o   (word_two_o),
    .word_three_o (word_three_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR: frame %0d: %s: got 0x%0h, expected 0x%0h",
             frames_checked, what, got, want);
    error_count++;
  endtask

  // Window model: appends one byte and, once eleven are held, either decodes
  // a frame and empties the window or drops the oldest byte.
  task automatic track_link_byte(input scfp_pkg::byte_t rx);
    scfp_pkg::byte_t sum;
    frame_rec_t      rec;
    int              i;
    held_bytes[held_count] = rx;
    held_count++;
    if (held_count == scfp_pkg::FrameLen) begin
      sum = '0;
      for (i = 0; i < scfp_pkg::SumLen; i++) sum = sum + held_bytes[i];
      if (held_bytes[0] == sync_setting && sum == held_bytes[scfp_pkg::SumLen]) begin
        rec.frame_type = held_bytes[1];
        rec.word_zero  = {held_bytes[3], held_bytes[2]};
        rec.word_one   = {held_bytes[5], held_bytes[4]};
        rec.word_two   = {held_bytes[7], held_bytes[6]};
        rec.word_three = {held_bytes[9], held_bytes[8]};
        frames_due.push_back(rec);
        for (i = 0; i < scfp_pkg::FrameLen; i++) held_bytes[i] = '0;
        held_count = 0;
      end else begin
        for (i = 0; i < scfp_pkg::FrameLen - 1; i++) held_bytes[i] = held_bytes[i + 1];
        held_bytes[scfp_pkg::FrameLen - 1] = '0;
        held_count = scfp_pkg::FrameLen - 1;
      end
    end
  endtask

  // Mostly uniform, with the two extremes favored.
  function automatic scfp_pkg::byte_t random_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_byte(input scfp_pkg::byte_t value);
    link_bytes.push_back(value);
    bytes_queued++;
  endtask

  // Builds one frame behind the given header, then damages it as asked.
  task automatic queue_frame(input scfp_pkg::byte_t head, input body_e body,
                             input flaw_e flaw);
    scfp_pkg::byte_t frame_bytes[scfp_pkg::FrameLen];
    scfp_pkg::byte_t sum;
    int              cut;
    int              i;
    cut = -1;
    frame_bytes[0] = head;
    if (flaw == FlawHeader) frame_bytes[0] = head ^ 8'($urandom_range(1, 255));
    for (i = 1; i < scfp_pkg::SumLen; i++) begin
      case (body)
        BodyOnes:  frame_bytes[i] = 8'hFF;
        BodyZeros: frame_bytes[i] = 8'h00;
        default:   frame_bytes[i] = random_byte();
      endcase
    end
    sum = '0;
    for (i = 0; i < scfp_pkg::SumLen; i++) sum = sum + frame_bytes[i];
    frame_bytes[scfp_pkg::SumLen] = sum;
    if (flaw == FlawChecksum) begin
      frame_bytes[scfp_pkg::SumLen] = sum + 8'($urandom_range(1, 255));
    end
    if (flaw == FlawShort) cut = $urandom_range(1, scfp_pkg::SumLen - 1);
    for (i = 0; i < scfp_pkg::FrameLen; i++) begin
      if (i != cut) queue_byte(frame_bytes[i]);
    end
  endtask

  // Random traffic: mostly good frames, some damaged ones, some noise.
  task automatic queue_traffic(input scfp_pkg::byte_t head, input int count);
    int start;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        queue_frame(head, BodyRandom, FlawNone);
      end else if (pick < 82) begin
        queue_frame(head, BodyRandom, flaw_e'($urandom_range(FlawChecksum, FlawShort)));
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(random_byte());
      end
    end
  endtask

  // Waits until every byte is taken and every predicted frame has come out.
  task automatic settle();
    int waited;
    waited = 0;
    while (bytes_accepted != bytes_queued) @(posedge clk_i);
    while (frames_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    while (frames_due.size() != 0) begin
      report_mismatch("frame never delivered", 0, frames_due[0].frame_type);
      void'(frames_due.pop_front());
    end
  endtask

  // Writes the sync byte; called right after a rising edge.
  task automatic write_sync(input scfp_pkg::byte_t value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sync_setting = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Byte driver: offers the next queued byte and tracks each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_link_byte(rx_byte_i);
        bytes_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (link_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= link_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: random back-pressure and field checks.
  always @(posedge clk_i) begin : watch_frames
    frame_rec_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          report_mismatch("frame with none pending", frame_type_o, 0);
        end else begin
          want = frames_due.pop_front();
          if (frame_type_o !== want.frame_type)
            report_mismatch("frame_type", frame_type_o, want.frame_type);
          if (word_zero_o !== want.word_zero)
            report_mismatch("word_zero", word_zero_o, want.word_zero);
          if (word_one_o !== want.word_one)
            report_mismatch("word_one", word_one_o, want.word_one);
          if (word_two_o !== want.word_two)
            report_mismatch("word_two", word_two_o, want.word_two);
          if (word_three_o !== want.word_three)
            report_mismatch("word_three", word_three_o, want.word_three);
        end
        frames_checked++;
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run_phases
    scfp_pkg::byte_t last_sync;
    for (int i = 0; i < scfp_pkg::FrameLen; i++) held_bytes[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 67;

    // Directed: a frame of all ones (the checksum wraps), then a stray byte
    // that forces one slide before a frame of all zeros.
    queue_frame(scfp_pkg::SyncReset, BodyOnes, FlawNone);
    queue_byte(8'h00);
    queue_frame(scfp_pkg::SyncReset, BodyZeros, FlawNone);
    settle();

    // Random traffic behind the reset sync byte.
    queue_traffic(scfp_pkg::SyncReset, 330);
    settle();

    // Lowest sync byte.
    write_sync(8'h00);
    queue_traffic(8'h00, 350);
    settle();

    // Highest sync byte, with the idle rates swapped.
    send_idle_pct = 67;
    recv_idle_pct = 38;
    write_sync(8'hFF);
    queue_traffic(8'hFF, 350);
    settle();

    // A random sync byte at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_sync = random_byte();
    write_sync(last_sync);
    queue_traffic(last_sync, 350);
    settle();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sync_checksum_frame_parser_core.f =====
rtl/scfp_pkg.sv
rtl/scfp_window.sv
rtl/sync_checksum_frame_parser_core.sv
test/sync_checksum_frame_parser_core_test.sv
